FILE: rtl/itrt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itrt_pkg: shared types and constants for the integer to radix text block
// Character codes, field widths, the queue item layout and the back-end
// state encoding.
// ----------------------------------------------------------------------------
package itrt_pkg;

    // default parameter values
    localparam int WORD_BITS_DEF   = 32;
    localparam int DIGIT_DEPTH_DEF = 64;

    // input and output field widths
    localparam int NUM_BITS   = 32;
    localparam int RADIX_BITS = 8;
    localparam int IN_DATA_W  = NUM_BITS + RADIX_BITS;
    localparam int CHAR_BITS  = 8;

    // base and remainder widths (base up to 16, shifted remainder up to 31)
    localparam int BASE_W = 5;
    localparam int REM_W  = 5;

    // quotient bits retired per cycle by the divider
    localparam int DIV_STEPS = 8;

    // decoupling queue: two entries
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_DEPTH = 2;

    // accepted bases
    localparam int RADIX_MIN = 2;
    localparam int RADIX_MAX = 16;
    localparam int RADIX_BIN = 2;
    localparam int RADIX_DEC = 10;
    localparam int RADIX_HEX = 16;

    // character codes
    localparam logic [CHAR_BITS-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_A_OFF = 8'h37;  // 'A' minus ten
    localparam logic [CHAR_BITS-1:0] CHAR_X     = 8'h78;
    localparam logic [CHAR_BITS-1:0] CHAR_B     = 8'h62;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;

    // uppercase digit character for a value 0..15
    function automatic logic [CHAR_BITS-1:0] digit_char(input logic [3:0] d);
        if (d < 4'd10) begin
            return CHAR_ZERO + {4'b0000, d};
        end
        return CHAR_A_OFF + {4'b0000, d};
    endfunction

    // classified item handed from front to back
    typedef struct packed {
        logic                 err;
        logic                 show_sign;
        logic                 has_prefix;
        logic [CHAR_BITS-1:0] prefix_char;
        logic [BASE_W-1:0]    base;
    } task_t;

    // back-end sequencer states
    typedef enum logic [2:0] {
        B_IDLE,
        B_ERR,
        B_DIV,
        B_PRE0,
        B_PRE1,
        B_SIGN,
        B_RD,
        B_LOAD
    } back_state_t;

endpackage
`default_nettype wire

FILE: rtl/itrt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itrt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. Read data holds while
// no read is issued.
// ----------------------------------------------------------------------------
module itrt_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

FILE: rtl/itrt_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itrt_fifo: two-entry queue between front and back
// Lets the front take a new item while the back is still converting.
// ----------------------------------------------------------------------------
module itrt_fifo
    import itrt_pkg::*;
#(
    parameter int DATA_W = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output logic      [DATA_W-1:0] pop_data
);

    logic [DATA_W-1:0]   mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/itrt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itrt_front: input classifier
// Checks the base, picks the prefix, decides on the minus sign and forms
// the magnitude to convert, then pushes the item into the queue.
// ----------------------------------------------------------------------------
module itrt_front
    import itrt_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
    output logic                      push_valid,
    input  wire logic                 push_ready,
    output task_t                     push_info,
    output logic      [WORD_BITS-1:0] push_val
);

    logic signed [NUM_BITS-1:0]   num_s;
    logic        [RADIX_BITS-1:0] radix;
    logic        [WORD_BITS-1:0]  val_ext;
    logic                         neg;
    logic                         show_sign;

    assign num_s = s_axis_tdata[NUM_BITS-1:0];
    assign radix = s_axis_tdata[IN_DATA_W-1:NUM_BITS];

    // value seen at the working width, sign taken from its top bit
    assign val_ext   = WORD_BITS'(num_s);
    assign neg       = val_ext[WORD_BITS-1];
    assign show_sign = neg && (radix == RADIX_BITS'(RADIX_DEC));

    // classification
    always_comb begin
        push_info.err         = !(radix inside {[RADIX_MIN:RADIX_MAX]});
        push_info.show_sign   = show_sign;
        push_info.base        = radix[BASE_W-1:0];
        push_info.has_prefix  = 1'b0;
        push_info.prefix_char = CHAR_NUL;
        if (radix == RADIX_BITS'(RADIX_HEX)) begin
            push_info.has_prefix  = 1'b1;
            push_info.prefix_char = CHAR_X;
        end else if (radix == RADIX_BITS'(RADIX_BIN)) begin
            push_info.has_prefix  = 1'b1;
            push_info.prefix_char = CHAR_B;
        end
    end

    // magnitude: negated only for signed decimal text
    assign push_val = show_sign ? (~val_ext + 1'b1) : val_ext;

    assign push_valid    = s_axis_tvalid;
    assign s_axis_tready = push_ready;

endmodule
`default_nettype wire

FILE: rtl/itrt_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itrt_back: conversion and character emission
// Divides the magnitude by the base with a restoring divider, DIV_STEPS
// bits a cycle, stores each digit character, then emits prefix, sign and
// the digits most significant first, or an error item for a bad base, through an output register.
// ----------------------------------------------------------------------------
module itrt_back
    import itrt_pkg::*;
#(
    parameter int WORD_BITS   = WORD_BITS_DEF,
    parameter int DIGIT_DEPTH = DIGIT_DEPTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 task_valid,
    output logic                      task_ready,
    input  wire task_t                task_info,
    input  wire logic [WORD_BITS-1:0] task_val,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [CHAR_BITS-1:0] m_axis_tdata,
    output logic                      m_axis_tlast,
    output logic      [0:0]           m_axis_tuser
);

    localparam int ADDR_W = $clog2(DIGIT_DEPTH);
    localparam int CNT_W  = $clog2(DIGIT_DEPTH + 1);
    localparam int IDX_W  = $clog2(WORD_BITS + 1);

    back_state_t state_reg, state_next;
    back_state_t first_emit;

    task_t                tsk_reg, tsk_next;
    logic [WORD_BITS-1:0] quo_reg, quo_next, quo_step;
    logic [REM_W-1:0]     rem_reg, rem_next, rem_step;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 div_last;

    logic                 out_valid_reg, out_valid_next;
    logic [CHAR_BITS-1:0] out_char_reg, out_char_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_err_reg, out_err_next;
    logic                 can_load;

    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [CHAR_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic [CHAR_BITS-1:0] rd_data;

    // digit store
    itrt_ram #(
        .DATA_W (CHAR_BITS),
        .DEPTH  (DIGIT_DEPTH)
    ) u_digit_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign can_load = !out_valid_reg || m_axis_tready;
    assign div_last = (32'(idx_reg) + DIV_STEPS) >= WORD_BITS;
    assign wr_addr  = cnt_reg[ADDR_W-1:0];
    assign wr_data  = digit_char(rem_step[3:0]);
    assign rd_addr  = ADDR_W'(cnt_reg - 1'b1);

    // divider slice: DIV_STEPS shift-compare-subtract steps
    always_comb begin
        logic [REM_W-1:0]     rem_v;
        logic [WORD_BITS-1:0] quo_v;
        rem_v = rem_reg;
        quo_v = quo_reg;
        for (int i = 0; i < DIV_STEPS; i++) begin
            if ((32'(idx_reg) + i) < WORD_BITS) begin
                rem_v = {rem_v[REM_W-2:0], quo_v[WORD_BITS-1]};
                quo_v = {quo_v[WORD_BITS-2:0], 1'b0};
                if (rem_v >= tsk_reg.base) begin
                    rem_v    = rem_v - tsk_reg.base;
                    quo_v[0] = 1'b1;
                end
            end
        end
        rem_step = rem_v;
        quo_step = quo_v;
    end

    // first character after the digits are ready
    always_comb begin
        if (tsk_reg.has_prefix) begin
            first_emit = B_PRE0;
        end else if (tsk_reg.show_sign) begin
            first_emit = B_SIGN;
        end else begin
            first_emit = B_RD;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (task_valid) begin
                    state_next = task_info.err ? B_ERR : B_DIV;
                end
            end
            B_ERR: begin
                if (can_load) begin
                    state_next = B_IDLE;
                end
            end
            B_DIV: begin
                if (div_last && (quo_step == '0)) begin
                    state_next = first_emit;
                end
            end
            B_PRE0: begin
                if (can_load) begin
                    state_next = B_PRE1;
                end
            end
            B_PRE1: begin
                if (can_load) begin
                    state_next = tsk_reg.show_sign ? B_SIGN : B_RD;
                end
            end
            B_SIGN: begin
                if (can_load) begin
                    state_next = B_RD;
                end
            end
            B_RD: begin
                state_next = B_LOAD;
            end
            B_LOAD: begin
                if (can_load) begin
                    state_next = (cnt_reg == CNT_W'(1)) ? B_IDLE : B_RD;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        task_ready     = 1'b0;
        tsk_next       = tsk_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        case (state_reg)
            B_IDLE: begin
                task_ready = 1'b1;
                if (task_valid) begin
                    tsk_next = task_info;
                    quo_next = task_val;
                    rem_next = '0;
                    idx_next = '0;
                    if (!task_info.err) begin
                        cnt_next = '0;
                    end
                end
            end
            B_ERR: begin
                if (can_load) begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_NUL;
                    out_last_next  = 1'b1;
                    out_err_next   = 1'b1;
                end
            end
            B_DIV: begin
                quo_next = quo_step;
                if (div_last) begin
                    // digit done: store it unless the store is full
                    wr_en    = (cnt_reg < CNT_W'(DIGIT_DEPTH));
                    cnt_next = wr_en ? (cnt_reg + 1'b1) : cnt_reg;
                    rem_next = '0;
                    idx_next = '0;
                end else begin
                    rem_next = rem_step;
                    idx_next = IDX_W'(32'(idx_reg) + DIV_STEPS);
                end
            end
            B_PRE0: begin
                if (can_load) begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_ZERO;
                    out_last_next  = 1'b0;
                    out_err_next   = 1'b0;
                end
            end
            B_PRE1: begin
                if (can_load) begin
                    out_valid_next = 1'b1;
                    out_char_next  = tsk_reg.prefix_char;
                    out_last_next  = 1'b0;
                    out_err_next   = 1'b0;
                end
            end
            B_SIGN: begin
                if (can_load) begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_MINUS;
                    out_last_next  = 1'b0;
                    out_err_next   = 1'b0;
                end
            end
            B_RD: begin
                rd_en = 1'b1;
            end
            B_LOAD: begin
                if (can_load) begin
                    out_valid_next = 1'b1;
                    out_char_next  = rd_data;
                    out_last_next  = (cnt_reg == CNT_W'(1));
                    out_err_next   = 1'b0;
                    cnt_next       = cnt_reg - 1'b1;
                end
            end
            default: begin
                task_ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        tsk_reg      <= tsk_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        idx_reg      <= idx_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_err_reg;

endmodule
`default_nettype wire

FILE: rtl/int_to_radix_text.sv
`default_nettype none
// ----------------------------------------------------------------------------
// int_to_radix_text: signed integer to text in base 2..16
// Emits uppercase digits most significant first, with 0x / 0b prefixes,
// a minus sign for negative decimal values and an error item for a bad base.
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata (low bit up)              tlast           tuser
//  s_axis    in   number[31:0], radix[39:32]      -               -
//  m_axis    out  char_out[7:0]                   last character  error[0]
//
//  Each digit is found by the divider, DIV_STEPS quotient bits at a time;
//  then the prefix characters and the sign are loaded into the output
//  register, and every digit takes a digit RAM read (B_RD) and an output
//  load (B_LOAD). A bad base costs one output item.
//  Reset clears the sequencer, the queue and the output valid; no sweep.
//  The two-entry queue keeps accepting items while the back end converts,
//  until both entries are full; a stalled m_axis holds the output register and the emitting states of the sequencer.
//
module int_to_radix_text
    import itrt_pkg::*;
#(
    parameter int WORD_BITS   = WORD_BITS_DEF,
    parameter int DIGIT_DEPTH = DIGIT_DEPTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [IN_DATA_W-1:0] s_axis_tdata,   // number[31:0], radix[39:32]
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [CHAR_BITS-1:0] m_axis_tdata,   // char_out[7:0]
    output logic                      m_axis_tlast,
    output logic      [0:0]           m_axis_tuser    // error[0]
);

    localparam int Q_W = $bits(task_t) + WORD_BITS;

    logic                 push_valid;
    logic                 push_ready;
    task_t                push_info;
    logic [WORD_BITS-1:0] push_val;
    logic                 pop_valid;
    logic                 pop_ready;
    logic [Q_W-1:0]       pop_data;
    task_t                pop_info;
    logic [WORD_BITS-1:0] pop_val;

    // classifier
    itrt_front #(
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_info     (push_info),
        .push_val      (push_val)
    );

    // decoupling queue
    itrt_fifo #(
        .DATA_W (Q_W)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_val, push_info}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign pop_info = pop_data[$bits(task_t)-1:0];
    assign pop_val  = pop_data[Q_W-1:$bits(task_t)];

    // converter and emitter
    itrt_back #(
        .WORD_BITS   (WORD_BITS),
        .DIGIT_DEPTH (DIGIT_DEPTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .task_valid    (pop_valid),
        .task_ready    (pop_ready),
        .task_info     (pop_info),
        .task_val      (pop_val),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
`default_nettype wire
